// ===== sv/ascii_integer_literal_parser_defines.svh =====
// Assertion macros for the integer literal parser.
// Included by the top level; no other dependencies.
`ifndef ASCII_INTEGER_LITERAL_PARSER_DEFINES_SVH
`define ASCII_INTEGER_LITERAL_PARSER_DEFINES_SVH

// Same-cycle implication under an active-low reset.
`define AIP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication under an active-low reset.
`define AIP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/aip_pkg.sv =====
// Shared types and constants for the integer literal parser.
// No dependencies; imported by every module of the block except aip_fifo.
package aip_pkg;

  typedef struct packed {
    logic [7:0] character;
    logic       final_char;
    logic       empty_literal;
    logic [3:0] type_code;
  } in_t;

  typedef struct packed {
    logic [63:0] parsed_value;
    logic [2:0]  status;
  } out_t;

  // Status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_TYPE    = 3'd1;
  localparam logic [2:0] ST_INVALID = 3'd2;
  localparam logic [2:0] ST_RANGE   = 3'd3;
  localparam logic [2:0] ST_NEGUNS  = 3'd4;

  // Highest type code that names a fixed-width integer
  localparam logic [3:0] TYPE_LAST_INT = 4'd7;

  // Characters of interest
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_X_LO  = 8'h78;
  localparam logic [7:0] CH_X_UP  = 8'h58;
  localparam logic [7:0] CH_B_LO  = 8'h62;
  localparam logic [7:0] CH_B_UP  = 8'h42;

  // Classified character, front to back
  typedef struct packed {
    logic       final_char;
    logic       empty_literal;
    logic [3:0] type_code;
    logic       is_minus;
    logic       is_zero;
    logic       is_x;
    logic       is_b;
    logic       is_hex;
    logic [3:0] dval;
  } cls_t;

  // End-of-literal record, back to result stage
  typedef struct packed {
    logic [63:0] magnitude;
    logic        is_negative;
    logic [3:0]  type_code;
    logic [2:0]  status;
    logic        partial;
  } fin_t;

endpackage

// ===== sv/aip_fifo.sv =====
// Small register queue with push/full and pop/empty handshakes.
// Generic; no package dependency.
module aip_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_wr, do_rd;

  assign full    = count_r == CW'(DEPTH);
  assign empty   = count_r == '0;
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ===== sv/aip_front.sv =====
// Front end: takes input words and classifies the character.
// Uses aip_pkg; feeds the mid queue.
module aip_front import aip_pkg::*; (
  input  logic in_push,
  input  in_t  in_word,
  output logic in_full,
  input  logic mid_full,
  output logic mid_wr,
  output cls_t mid_data
);

  logic [7:0] c;

  assign c       = in_word.character;
  assign in_full = mid_full;
  assign mid_wr  = in_push && !mid_full;

  always_comb begin
    mid_data               = '0;
    mid_data.final_char    = in_word.final_char;
    mid_data.empty_literal = in_word.empty_literal;
    mid_data.type_code     = in_word.type_code;
    mid_data.is_minus      = c == CH_MINUS;
    mid_data.is_zero       = c == CH_ZERO;
    mid_data.is_x          = (c == CH_X_LO) || (c == CH_X_UP);
    mid_data.is_b          = (c == CH_B_LO) || (c == CH_B_UP);
    if (c inside {[8'h30:8'h39]}) begin
      mid_data.is_hex = 1'b1;
      mid_data.dval   = c[3:0];
    end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      // letters a..f sit at low nibble 1..6
      mid_data.is_hex = 1'b1;
      mid_data.dval   = c[3:0] + 4'd9;
    end
  end

endmodule

// ===== sv/aip_back.sv =====
// Back end: sign/prefix sequencer and 64-bit magnitude accumulator.
// Uses aip_pkg; pops the mid queue, hands finished literals on.
module aip_back import aip_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  cls_t mid_data,
  input  logic mid_empty,
  output logic mid_pop,
  input  logic fin_ready,
  output logic fin_valid,
  output fin_t fin_data
);

  typedef enum logic [2:0] {
    PH_START,
    PH_MINUS,
    PH_ZERO,
    PH_PREFIX,
    PH_DIGITS
  } phase_t;

  typedef enum logic [1:0] {
    RAD_DEC,
    RAD_HEX,
    RAD_BIN
  } radix_t;

  phase_t      phase_r, phase_nxt;
  radix_t      radix_r, radix_nxt;
  logic        neg_r, neg_nxt;
  logic [63:0] mag_r, mag_nxt;
  logic [2:0]  st_r, st_nxt;
  logic [3:0]  type_r, type_nxt;

  logic [67:0] prod;
  logic [4:0]  rval;
  logic        ovf;
  logic        take_dig;

  assign mid_pop = !mid_empty && fin_ready;

  // magnitude * radix + digit, shift and add
  always_comb begin
    case (radix_r)
      RAD_HEX: begin
        prod = {mag_r, 4'b0};
        rval = 5'd16;
      end
      RAD_BIN: begin
        prod = {3'b0, mag_r, 1'b0};
        rval = 5'd2;
      end
      default: begin
        prod = {1'b0, mag_r, 3'b0} + {3'b0, mag_r, 1'b0};
        rval = 5'd10;
      end
    endcase
    prod = prod + {64'b0, mid_data.dval};
  end

  assign ovf = |prod[67:64];

  always_comb begin
    phase_nxt = phase_r;
    radix_nxt = radix_r;
    neg_nxt   = neg_r;
    mag_nxt   = mag_r;
    st_nxt    = st_r;
    type_nxt  = type_r;
    take_dig  = 1'b0;
    fin_valid = 1'b0;
    fin_data  = '0;
    if (mid_pop) begin
      if (phase_r == PH_START && mid_data.empty_literal) begin
        fin_valid        = 1'b1;
        fin_data.status  = ST_TYPE;
        phase_nxt        = PH_START;
        radix_nxt        = RAD_DEC;
        neg_nxt          = 1'b0;
        mag_nxt          = '0;
        st_nxt           = ST_OK;
        type_nxt         = '0;
      end else begin
        if (phase_r == PH_START) begin
          type_nxt = mid_data.type_code;
          if (mid_data.type_code > TYPE_LAST_INT && st_r == ST_OK) begin
            st_nxt = ST_TYPE;
          end
        end
        if (!mid_data.empty_literal && st_nxt == ST_OK) begin
          case (phase_r)
            PH_START, PH_MINUS: begin
              if (phase_r == PH_START && mid_data.is_minus) begin
                neg_nxt   = 1'b1;
                phase_nxt = PH_MINUS;
              end else if (mid_data.is_zero) begin
                phase_nxt = PH_ZERO;
              end else begin
                take_dig = 1'b1;
              end
            end
            PH_ZERO: begin
              if (mid_data.is_x) begin
                radix_nxt = RAD_HEX;
                phase_nxt = PH_PREFIX;
              end else if (mid_data.is_b) begin
                radix_nxt = RAD_BIN;
                phase_nxt = PH_PREFIX;
              end else begin
                take_dig = 1'b1;
              end
            end
            default: begin
              take_dig = 1'b1;
            end
          endcase
          if (take_dig) begin
            if (!mid_data.is_hex) begin
              st_nxt = ST_INVALID;
            end else if ({1'b0, mid_data.dval} >= rval || ovf) begin
              st_nxt = ST_RANGE;
            end else begin
              mag_nxt   = prod[63:0];
              phase_nxt = PH_DIGITS;
            end
          end
        end
        if (mid_data.final_char) begin
          fin_valid            = 1'b1;
          fin_data.magnitude   = mag_nxt;
          fin_data.is_negative = neg_nxt;
          fin_data.type_code   = type_nxt;
          fin_data.status      = st_nxt;
          fin_data.partial     = (phase_nxt == PH_MINUS) || (phase_nxt == PH_PREFIX);
          phase_nxt            = PH_START;
          radix_nxt            = RAD_DEC;
          neg_nxt              = 1'b0;
          mag_nxt              = '0;
          st_nxt               = ST_OK;
          type_nxt             = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_START;
      radix_r <= RAD_DEC;
      neg_r   <= 1'b0;
      mag_r   <= '0;
      st_r    <= ST_OK;
      type_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      radix_r <= radix_nxt;
      neg_r   <= neg_nxt;
      mag_r   <= mag_nxt;
      st_r    <= st_nxt;
      type_r  <= type_nxt;
    end
  end

endmodule

// ===== sv/aip_final.sv =====
// Result stage: range check, two's complement and masking per type.
// Uses aip_pkg; writes the result queue.
module aip_final import aip_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic fin_valid,
  input  fin_t fin_data,
  output logic fin_ready,
  input  logic res_full,
  output logic res_wr,
  output out_t res_data
);

  logic        valid_r;
  fin_t        rec_r;
  logic [63:0] mask;
  logic [63:0] half;
  logic [63:0] top;
  logic        is_signed;
  logic [2:0]  st;
  logic [63:0] val;

  assign fin_ready = !valid_r || !res_full;
  assign res_wr    = valid_r && !res_full;
  assign is_signed = !rec_r.type_code[2];

  always_comb begin
    case (rec_r.type_code[1:0])
      2'd0:    mask = 64'h0000_0000_0000_00FF;
      2'd1:    mask = 64'h0000_0000_0000_FFFF;
      2'd2:    mask = 64'h0000_0000_FFFF_FFFF;
      default: mask = 64'hFFFF_FFFF_FFFF_FFFF;
    endcase
    half = (mask >> 1) + 64'd1;
    top  = is_signed ? (mask >> 1) : mask;
  end

  always_comb begin
    st  = rec_r.status;
    val = '0;
    if (st == ST_OK && rec_r.partial) begin
      st = ST_INVALID;
    end
    if (st == ST_OK) begin
      if (rec_r.is_negative) begin
        if (!is_signed) begin
          st = ST_NEGUNS;
        end else if (rec_r.magnitude > half) begin
          st = ST_RANGE;
        end else begin
          val = (~rec_r.magnitude + 64'd1) & mask;
        end
      end else if (rec_r.magnitude > top) begin
        st = ST_RANGE;
      end else begin
        val = rec_r.magnitude;
      end
    end
    res_data.parsed_value = val;
    res_data.status       = st;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (fin_ready) begin
      valid_r <= fin_valid;
    end
  end

  // hold the record while the result queue is full
  always_ff @(posedge clk) begin
    if (fin_ready) begin
      rec_r <= fin_data;
    end
  end

endmodule

// ===== sv/ascii_integer_literal_parser.sv =====
// Integer literal parser top: front, mid queue, back, result stage and result queue.
// Uses aip_pkg, aip_fifo, aip_front, aip_back, aip_final and the assertion macros.
//
//   side    handshake        payload
//   input   push / full      in_word  (in_t)
//   result  empty / pop      out_word (out_t)
//
// One character word per cycle is sustained while the result queue has room;
// the accumulator step (magnitude times radix plus digit with overflow check)
// is combinational. A final word's result passes the mid queue and the result
// stage register before it enters the result queue, and can then be popped.
// Reset is synchronous; all queues come up empty and the parser at literal start.
// A full result queue holds the result stage, which holds the accumulator,
// which lets the mid queue fill and raises full.
`include "ascii_integer_literal_parser_defines.svh"

module ascii_integer_literal_parser import aip_pkg::*; #(
  parameter int MID_DEPTH = 2,
  parameter int OUT_DEPTH = 2
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  output logic full,
  input  in_t  in_word,
  output logic empty,
  input  logic pop,
  output out_t out_word
);

  logic mid_wr, mid_full, mid_pop, mid_empty;
  cls_t mid_wdata, mid_rdata;
  logic fin_valid, fin_ready;
  fin_t fin_data;
  logic res_wr, res_full;
  out_t res_data;

  aip_front u_front (
    .in_push  (push),
    .in_word  (in_word),
    .in_full  (full),
    .mid_full (mid_full),
    .mid_wr   (mid_wr),
    .mid_data (mid_wdata)
  );

  aip_fifo #(
    .WIDTH ($bits(cls_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (mid_wr),
    .wr_data (mid_wdata),
    .full    (mid_full),
    .rd_en   (mid_pop),
    .rd_data (mid_rdata),
    .empty   (mid_empty)
  );

  aip_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .mid_data  (mid_rdata),
    .mid_empty (mid_empty),
    .mid_pop   (mid_pop),
    .fin_ready (fin_ready),
    .fin_valid (fin_valid),
    .fin_data  (fin_data)
  );

  aip_final u_final (
    .clk       (clk),
    .rst_n     (rst_n),
    .fin_valid (fin_valid),
    .fin_data  (fin_data),
    .fin_ready (fin_ready),
    .res_full  (res_full),
    .res_wr    (res_wr),
    .res_data  (res_data)
  );

  aip_fifo #(
    .WIDTH ($bits(out_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_wr),
    .wr_data (res_data),
    .full    (res_full),
    .rd_en   (pop),
    .rd_data (out_word),
    .empty   (empty)
  );

  `AIP_ASSERT_NOW(a_err_value_zero, clk, rst_n,
                  !empty && out_word.status != ST_OK, out_word.parsed_value == 64'd0,
                  "error result with nonzero value")
  `AIP_ASSERT_NOW(a_mid_pop_valid, clk, rst_n, mid_pop, !mid_empty,
                  "back popped an empty mid queue")
  `AIP_ASSERT_NEXT(a_fin_lands, clk, rst_n, fin_valid && fin_ready, res_wr || res_full,
                   "finished literal lost in result stage")

endmodule
